>>> design/btt_pkg.sv
// btt_pkg: shared widths, constants and the divider word type
// used by the interfaces, the front end, the divider cells, the back end and the top level
`default_nettype none
package btt_pkg;
    localparam int COORD_W        = 24;
    localparam int WEIGHT_W       = 24;
    localparam int TOL_W          = 17;
    localparam int TOL_FRAC_BITS  = 16;
    localparam int WEIGHT_FRAC_DEF = 16;
    localparam int MAG_BITS       = 50;
    localparam int Q_BITS         = 41;
    localparam int ACC_W          = 44;

    localparam logic [Q_BITS:0] Q_CAP = (Q_BITS + 1)'(1) << (Q_BITS - 1);
    localparam logic signed [ACC_W-1:0] W_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] W_MIN = -ACC_W'(8388608);

    typedef struct packed {
        logic [MAG_BITS-1:0] un_v;
        logic [MAG_BITS-1:0] un_w;
        logic [MAG_BITS-1:0] ud;
        logic [MAG_BITS-1:0] r_v;
        logic [MAG_BITS-1:0] r_w;
        logic [Q_BITS-1:0]   q_v;
        logic [Q_BITS-1:0]   q_w;
        logic                neg_v;
        logic                neg_w;
        logic                deg;
    } div_word_t;
endpackage
`default_nettype wire

>>> design/btt_if.sv
// btt_if: valid/ready channel interfaces for request, result and configuration words
// depends on btt_pkg
`default_nettype none
interface btt_req_if;
    import btt_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
    modport source (output valid, point_x, point_y, vert_a_x, vert_a_y,
                    vert_b_x, vert_b_y, vert_c_x, vert_c_y, input ready);
    modport sink (input valid, point_x, point_y, vert_a_x, vert_a_y,
                  vert_b_x, vert_b_y, vert_c_x, vert_c_y, output ready);
endinterface

interface btt_rsp_if;
    import btt_pkg::*;
    logic valid;
    logic ready;
    logic inside_res;
    logic signed [WEIGHT_W-1:0] weight_u;
    logic signed [WEIGHT_W-1:0] weight_v;
    logic signed [WEIGHT_W-1:0] weight_w;
    logic degenerate;
    modport source (output valid, inside_res, weight_u, weight_v, weight_w, degenerate,
                    input ready);
    modport sink (input valid, inside_res, weight_u, weight_v, weight_w, degenerate,
                  output ready);
endinterface

interface btt_cfg_if;
    import btt_pkg::*;
    logic valid;
    logic ready;
    logic [TOL_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> design/btt_front.sv
// btt_front: edge differences, cross products, determinant and numerator magnitudes
// depends on btt_pkg, btt_if
`default_nettype none
module btt_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    btt_req_if.sink   req,
    output logic      valid,
    output btt_pkg::div_word_t word
);
    import btt_pkg::*;
    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic [2:0] valid_reg;
    logic signed [DW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, qx_reg, qy_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [SW-1:0] det_reg, nv_reg, nw_reg;
    div_word_t word_reg;
    logic valid_out_reg;
    logic signed [SW-1:0] det_abs, nv_abs, nw_abs;

    assign req.ready = advance;

    always_comb
    begin
        det_abs = det_reg[SW-1] ? -det_reg : det_reg;
        nv_abs  = nv_reg[SW-1] ? -nv_reg : nv_reg;
        nw_abs  = nw_reg[SW-1] ? -nw_reg : nw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            valid_out_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[1:0], req.valid};
            valid_out_reg <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e0x_reg <= DW'(req.vert_b_x) - DW'(req.vert_a_x);
            e0y_reg <= DW'(req.vert_b_y) - DW'(req.vert_a_y);
            e1x_reg <= DW'(req.vert_c_x) - DW'(req.vert_a_x);
            e1y_reg <= DW'(req.vert_c_y) - DW'(req.vert_a_y);
            qx_reg  <= DW'(req.point_x) - DW'(req.vert_a_x);
            qy_reg  <= DW'(req.point_y) - DW'(req.vert_a_y);
            p0_reg  <= PW'(e0x_reg) * PW'(e1y_reg);
            p1_reg  <= PW'(e1x_reg) * PW'(e0y_reg);
            p2_reg  <= PW'(qx_reg) * PW'(e1y_reg);
            p3_reg  <= PW'(e1x_reg) * PW'(qy_reg);
            p4_reg  <= PW'(e0x_reg) * PW'(qy_reg);
            p5_reg  <= PW'(qx_reg) * PW'(e0y_reg);
            det_reg <= SW'(p0_reg) - SW'(p1_reg);
            nv_reg  <= SW'(p2_reg) - SW'(p3_reg);
            nw_reg  <= SW'(p4_reg) - SW'(p5_reg);
            word_reg.ud    <= det_abs[MAG_BITS-1:0];
            word_reg.un_v  <= nv_abs[MAG_BITS-1:0];
            word_reg.un_w  <= nw_abs[MAG_BITS-1:0];
            word_reg.r_v   <= '0;
            word_reg.r_w   <= '0;
            word_reg.q_v   <= '0;
            word_reg.q_w   <= '0;
            word_reg.neg_v <= nv_reg[SW-1] ^ det_reg[SW-1];
            word_reg.neg_w <= nw_reg[SW-1] ^ det_reg[SW-1];
            word_reg.deg   <= (det_reg == '0);
        end
    end

    assign valid = valid_out_reg;
    assign word  = word_reg;
endmodule
`default_nettype wire

>>> design/btt_div_cell.sv
// btt_div_cell: one restoring division step for both weights, one quotient bit per cell
// depends on btt_pkg
`default_nettype none
module btt_div_cell #(
    parameter int STEP = 0
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire logic valid_in,
    input  btt_pkg::div_word_t word_in,
    output logic      valid_out,
    output btt_pkg::div_word_t word_out
);
    import btt_pkg::*;
    localparam int BIT_IDX = (STEP < MAG_BITS) ? MAG_BITS - 1 - STEP : 0;

    logic valid_reg;
    div_word_t word_reg;
    div_word_t word_next;
    logic bit_v, bit_w;
    logic [MAG_BITS:0] rs_v, rs_w;
    logic [Q_BITS:0] qs_v, qs_w;
    logic take_v, take_w;

    always_comb
    begin
        if (STEP < MAG_BITS)
        begin
            bit_v = word_in.un_v[BIT_IDX];
            bit_w = word_in.un_w[BIT_IDX];
        end
        else
        begin
            bit_v = 1'b0;
            bit_w = 1'b0;
        end
        rs_v = {word_in.r_v, bit_v};
        rs_w = {word_in.r_w, bit_w};
        take_v = rs_v >= {1'b0, word_in.ud};
        take_w = rs_w >= {1'b0, word_in.ud};
        qs_v = {word_in.q_v, take_v};
        qs_w = {word_in.q_w, take_w};
        word_next = word_in;
        word_next.r_v = take_v ? MAG_BITS'(rs_v - {1'b0, word_in.ud}) : MAG_BITS'(rs_v);
        word_next.r_w = take_w ? MAG_BITS'(rs_w - {1'b0, word_in.ud}) : MAG_BITS'(rs_w);
        word_next.q_v = (qs_v > Q_CAP) ? Q_BITS'(Q_CAP) : Q_BITS'(qs_v);
        word_next.q_w = (qs_w > Q_CAP) ? Q_BITS'(Q_CAP) : Q_BITS'(qs_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            word_reg <= word_next;
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;
endmodule
`default_nettype wire

>>> design/btt_back.sv
// btt_back: signed weights, u, bounds test, saturation and the output register
// depends on btt_pkg, btt_if
`default_nettype none
module btt_back #(
    parameter int WEIGHT_FRAC_BITS = btt_pkg::WEIGHT_FRAC_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic valid_in,
    input  btt_pkg::div_word_t word_in,
    input  wire logic [btt_pkg::TOL_W-1:0] tolerance,
    output logic      advance,
    btt_rsp_if.source rsp
);
    import btt_pkg::*;
    localparam int SHL = (WEIGHT_FRAC_BITS >= TOL_FRAC_BITS) ? WEIGHT_FRAC_BITS - TOL_FRAC_BITS : 0;
    localparam int SHR = (WEIGHT_FRAC_BITS < TOL_FRAC_BITS) ? TOL_FRAC_BITS - WEIGHT_FRAC_BITS : 0;
    localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) << WEIGHT_FRAC_BITS;

    logic valid_mid_reg;
    logic signed [ACC_W-1:0] u_reg, v_reg, w_reg;
    logic deg_reg;
    logic signed [ACC_W-1:0] v_s, w_s, tol, lo, hi;
    logic out_valid_reg, inside_reg, deg_out_reg;
    logic signed [WEIGHT_W-1:0] wu_reg, wv_reg, ww_reg;

    function automatic logic signed [WEIGHT_W-1:0] sat(input logic signed [ACC_W-1:0] x);
        logic signed [WEIGHT_W-1:0] y;
        if (x > W_MAX)
            y = WEIGHT_W'(W_MAX);
        else if (x < W_MIN)
            y = WEIGHT_W'(W_MIN);
        else
            y = WEIGHT_W'(x);
        return y;
    endfunction

    assign advance = !out_valid_reg || rsp.ready;

    always_comb
    begin
        v_s = word_in.neg_v ? -ACC_W'(word_in.q_v) : ACC_W'(word_in.q_v);
        w_s = word_in.neg_w ? -ACC_W'(word_in.q_w) : ACC_W'(word_in.q_w);
        tol = (ACC_W'(tolerance) << SHL) >>> SHR;
        lo  = -tol;
        hi  = ONE + tol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_mid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_mid_reg <= valid_in;
            out_valid_reg <= valid_mid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v_reg   <= v_s;
            w_reg   <= w_s;
            u_reg   <= ONE - v_s - w_s;
            deg_reg <= word_in.deg;
            deg_out_reg <= deg_reg;
            inside_reg  <= !deg_reg && u_reg >= lo && u_reg <= hi && v_reg >= lo
                           && v_reg <= hi && w_reg >= lo && w_reg <= hi;
            wu_reg <= deg_reg ? '0 : sat(u_reg);
            wv_reg <= deg_reg ? '0 : sat(v_reg);
            ww_reg <= deg_reg ? '0 : sat(w_reg);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.inside_res = inside_reg;
    assign rsp.weight_u   = wu_reg;
    assign rsp.weight_v   = wv_reg;
    assign rsp.weight_w   = ww_reg;
    assign rsp.degenerate = deg_out_reg;
endmodule
`default_nettype wire

>>> design/barycentric_triangle_test_core.sv
// barycentric_triangle_test_core: top level of the 2D barycentric point-in-triangle test
// depends on btt_pkg, btt_if, btt_front, btt_div_cell, btt_back
//
// usage
//   req: one word per test, point and three vertices in signed Q11.12
//   rsp: one word per test, inside flag, weights u v w in signed Q7.16, degenerate flag
//   cfg: tolerance write, always ready, write only while no test is in flight
// throughput: one word per cycle, back to back, while the pipeline is not held
// pipeline: the front end, then the divider chain, then the back end
//   divider chain: one quotient bit per cell, 50 + WEIGHT_FRAC_BITS cells
// the whole pipeline holds while the output register is full and rsp.ready is low;
//   req.ready follows that, so no word is dropped
// reset clears all valid bits and sets tolerance to zero
`default_nettype none
module barycentric_triangle_test_core #(
    parameter int WEIGHT_FRAC_BITS = btt_pkg::WEIGHT_FRAC_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    btt_req_if.sink   req,
    btt_rsp_if.source rsp,
    btt_cfg_if.sink   cfg
);
    import btt_pkg::*;
    localparam int STEPS = MAG_BITS + WEIGHT_FRAC_BITS;

    logic [TOL_W-1:0] tolerance_reg;
    logic advance;
    logic valid_chain [0:STEPS];
    div_word_t word_chain [0:STEPS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= '0;
        else if (cfg.valid)
            tolerance_reg <= cfg.data;
    end

    btt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req),
        .valid   (valid_chain[0]),
        .word    (word_chain[0])
    );

    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        btt_div_cell #(.STEP(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_chain[k]),
            .word_in   (word_chain[k]),
            .valid_out (valid_chain[k+1]),
            .word_out  (word_chain[k+1])
        );
    end

    btt_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_chain[STEPS]),
        .word_in   (word_chain[STEPS]),
        .tolerance (tolerance_reg),
        .advance   (advance),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire
